>>> design/ign3d_pkg.sv
// Package for the 3D gradient noise block: constants, types and arithmetic helpers.
`timescale 1ns / 1ps
package ign3d_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned TableSize = 256;
  localparam int unsigned TableAw   = $clog2(TableSize);
  localparam int unsigned NumAxes   = 3;

  // Input item commands
  typedef enum logic {
    CmdLoad = 1'b0,
    CmdEval = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgOffsetX = 2'd0,
    CfgOffsetY = 2'd1,
    CfgOffsetZ = 2'd2
  } cfg_idx_e;

  // Gradient and interpolation values, scaled by 2^16
  typedef logic signed [19:0] val_t;
  // Corner-relative coordinate, fraction or fraction minus one
  typedef logic signed [16:0] rel_t;
  // Fade weight, 0 to 2^16
  typedef logic [16:0] wgt_t;

  // Dot product with one of the cube edge directions, chosen by k
  function automatic val_t grad_q(logic [3:0] k, rel_t x, rel_t y, rel_t z);
    val_t u;
    val_t v;
    u = (k < 4'd8) ? val_t'(x) : val_t'(y);
    if (k < 4'd4) begin
      v = val_t'(y);
    end else if (k == 4'd12 || k == 4'd14) begin
      v = val_t'(x);
    end else begin
      v = val_t'(z);
    end
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  // p + round_half_up(w * (q - p) / 2^16)
  function automatic val_t lerp_q(wgt_t w, val_t p, val_t q);
    logic signed [20:0] diff;
    logic signed [38:0] prod;
    logic signed [38:0] rs;
    diff = 21'(q) - 21'(p);
    prod = 39'($signed({1'b0, w})) * 39'(diff);
    rs   = (prod + 39'sd32768) >>> FracBits;
    return p + $signed(rs[19:0]);
  endfunction

endpackage

>>> design/improved_gradient_noise_3d_top.sv
// Top level of the 3D gradient noise block: eight-stage evaluation pipeline.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_ready_o    | command, load index/value, x/y/z
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i (24 bits)
//  out     | source    | out_valid_o / out_ready_i  | noise_value_o (signed Q2.16)
//
// One item enters per cycle while the output is not stalled; an evaluation is registered
// at every stage until it reaches the output register.
// The depth is set by three chained table reads (each a registered memory read) in
// parallel with the five-multiply fade, then gradient, three lerp levels and saturation.
// Loads flow down the pipe and write each table copy in the stage that reads it.
// Reset clears valid bits and offsets; table contents stay undefined until loaded.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
`timescale 1ns / 1ps
module improved_gradient_noise_3d_top import ign3d_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [7:0]                load_index_i,
  input  logic [7:0]                load_value_i,
  input  logic signed [31:0]        coord_x_i,
  input  logic signed [31:0]        coord_y_i,
  input  logic signed [31:0]        coord_z_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [23:0]               cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [17:0]        noise_value_o
);

  logic en;

  // Offsets
  logic [NumAxes-1:0][23:0] off_q;

  // Valid bits: evaluate beats per stage, load beats for the table stages
  logic [7:1] ev_q;
  logic [3:1] ld_q;

  // Payload per stage
  logic [TableAw-1:0]            li_q [1:3];
  logic [7:0]                    lv_q [1:3];
  logic [NumAxes-1:0][7:0]       cell_q [1:3];
  logic [NumAxes-1:0][15:0]      frac_q [1:4];
  logic [NumAxes-1:0][15:0]      frac_d;
  logic [NumAxes-1:0][7:0]       cell_d;

  // Fade pipeline
  logic signed [38:0]            ta_q [NumAxes];
  logic signed [38:0]            ta_d [NumAxes];
  logic [16:0]                   c_q  [NumAxes];
  logic [16:0]                   c_d  [NumAxes];
  logic signed [22:0]            b_q  [NumAxes];
  logic signed [22:0]            b_d  [NumAxes];
  logic [16:0]                   dd_q [NumAxes];
  logic [16:0]                   dd_d [NumAxes];
  logic [NumAxes-1:0][16:0]      fd_q [4:7];
  logic [NumAxes-1:0][16:0]      fd_d;

  // Table copies and read data
  logic [7:0]                    mem1_q [TableSize];
  logic [7:0]                    mem2_q [2][TableSize];
  logic [7:0]                    mem3_q [4][TableSize];
  logic [7:0]                    px_q [2];
  logic [7:0]                    pab_q [4];
  logic [7:0]                    h_q [8];
  logic [TableAw-1:0]            addr2 [2];
  logic [TableAw-1:0]            addr3 [4];

  // Interpolation pipeline
  val_t                          g_q [8];
  val_t                          g_d [8];
  val_t                          lp_q [4];
  val_t                          m_q [2];
  val_t                          r_d;
  logic signed [17:0]            noise_q;
  logic signed [17:0]            noise_d;
  logic                          out_valid_q;

  // Advance the whole pipe unless the output beat is stuck
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign noise_value_o = noise_q;

  // Hold offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOffsetX: off_q[0] <= cfg_data_i;
        CfgOffsetY: off_q[1] <= cfg_data_i;
        CfgOffsetZ: off_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Split coordinate plus offset into cell and fraction
  always_comb begin
    logic [23:0] s [NumAxes];
    s[0] = coord_x_i[23:0] + off_q[0];
    s[1] = coord_y_i[23:0] + off_q[1];
    s[2] = coord_z_i[23:0] + off_q[2];
    for (int ch = 0; ch < NumAxes; ch++) begin
      cell_d[ch] = s[ch][23:16];
      frac_d[ch] = s[ch][15:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= '0;
      ld_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ev_q        <= {ev_q[6:1], in_valid_i && (command_i == CmdEval)};
      ld_q        <= {ld_q[2:1], in_valid_i && (command_i == CmdLoad)};
      out_valid_q <= ev_q[7];
    end
  end

  // Fade: stage 1 products, stage 2 rounding and cube, stage 3 final product
  always_comb begin
    logic [15:0]        t;
    logic signed [21:0] a;
    logic [31:0]        tt;
    logic signed [38:0] rta;
    logic [32:0]        cx;
    logic signed [40:0] pr;
    logic signed [40:0] rs;
    for (int ch = 0; ch < NumAxes; ch++) begin
      t        = frac_q[1][ch];
      a        = $signed(22'(t) * 22'd6) - 22'sd983040;
      ta_d[ch] = 39'($signed({1'b0, t})) * 39'(a);
      tt       = 32'(t) * 32'(t);
      c_d[ch]  = 17'((33'(tt) + 33'd32768) >> FracBits);

      rta      = (ta_q[ch] + 39'sd32768) >>> FracBits;
      b_d[ch]  = 23'(rta) + 23'sd655360;
      cx       = 33'(c_q[ch]) * 33'(frac_q[2][ch]);
      dd_d[ch] = 17'((cx + 33'd32768) >> FracBits);

      pr = 41'($signed({1'b0, dd_q[ch]})) * 41'(b_q[ch]);
      rs = (pr + 41'sd32768) >>> FracBits;
      if (rs < 41'sd0) begin
        fd_d[ch] = '0;
      end else if (rs > 41'sd65536) begin
        fd_d[ch] = 17'd65536;
      end else begin
        fd_d[ch] = 17'(rs);
      end
    end
  end

  // Hash addresses for the second and third table levels
  always_comb begin
    addr2[0] = px_q[0] + cell_q[2][1];
    addr2[1] = px_q[1] + cell_q[2][1];
    addr3[0] = pab_q[0] + cell_q[3][2];   // AA
    addr3[1] = pab_q[2] + cell_q[3][2];   // BA
    addr3[2] = pab_q[1] + cell_q[3][2];   // AB
    addr3[3] = pab_q[3] + cell_q[3][2];   // BB
  end

  // Gradients at the eight corners
  always_comb begin
    rel_t x0, x1, y0, y1, z0, z1;
    x0 = $signed({1'b0, frac_q[4][0]});
    x1 = $signed({1'b1, frac_q[4][0]});
    y0 = $signed({1'b0, frac_q[4][1]});
    y1 = $signed({1'b1, frac_q[4][1]});
    z0 = $signed({1'b0, frac_q[4][2]});
    z1 = $signed({1'b1, frac_q[4][2]});
    g_d[0] = grad_q(h_q[0][3:0], x0, y0, z0);
    g_d[1] = grad_q(h_q[1][3:0], x1, y0, z0);
    g_d[2] = grad_q(h_q[2][3:0], x0, y1, z0);
    g_d[3] = grad_q(h_q[3][3:0], x1, y1, z0);
    g_d[4] = grad_q(h_q[4][3:0], x0, y0, z1);
    g_d[5] = grad_q(h_q[5][3:0], x1, y0, z1);
    g_d[6] = grad_q(h_q[6][3:0], x0, y1, z1);
    g_d[7] = grad_q(h_q[7][3:0], x1, y1, z1);
  end

  // Last lerp and saturation
  always_comb begin
    r_d = lerp_q(fd_q[7][2], m_q[0], m_q[1]);
    if (r_d > 20'sd131071) begin
      noise_d = 18'sd131071;
    end else if (r_d < -20'sd131072) begin
      noise_d = -18'sd131072;
    end else begin
      noise_d = r_d[17:0];
    end
  end

  // Table copies: each level written by loads as they pass its stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ld_q[1]) begin
        mem1_q[li_q[1]] <= lv_q[1];
      end
      if (ld_q[2]) begin
        for (int k = 0; k < 2; k++) begin
          mem2_q[k][li_q[2]] <= lv_q[2];
        end
      end
      if (ld_q[3]) begin
        for (int k = 0; k < 4; k++) begin
          mem3_q[k][li_q[3]] <= lv_q[3];
        end
      end
      px_q[0] <= mem1_q[cell_q[1][0]];
      px_q[1] <= mem1_q[cell_q[1][0] + 8'd1];
      for (int k = 0; k < 2; k++) begin
        pab_q[2*k]   <= mem2_q[k][addr2[k]];
        pab_q[2*k+1] <= mem2_q[k][addr2[k] + 8'd1];
      end
      for (int k = 0; k < 4; k++) begin
        h_q[k]   <= mem3_q[k][addr3[k]];
        h_q[k+4] <= mem3_q[k][addr3[k] + 8'd1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      li_q[1]   <= load_index_i;
      lv_q[1]   <= load_value_i;
      cell_q[1] <= cell_d;
      frac_q[1] <= frac_d;
      for (int s = 2; s <= 3; s++) begin
        li_q[s]   <= li_q[s-1];
        lv_q[s]   <= lv_q[s-1];
        cell_q[s] <= cell_q[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
        frac_q[s] <= frac_q[s-1];
      end
      for (int ch = 0; ch < NumAxes; ch++) begin
        ta_q[ch] <= ta_d[ch];
        c_q[ch]  <= c_d[ch];
        b_q[ch]  <= b_d[ch];
        dd_q[ch] <= dd_d[ch];
      end
      fd_q[4] <= fd_d;
      for (int s = 5; s <= 7; s++) begin
        fd_q[s] <= fd_q[s-1];
      end
      for (int k = 0; k < 8; k++) begin
        g_q[k] <= g_d[k];
      end
      for (int k = 0; k < 4; k++) begin
        lp_q[k] <= lerp_q(fd_q[5][0], g_q[2*k], g_q[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
        m_q[k] <= lerp_q(fd_q[6][1], lp_q[2*k], lp_q[2*k+1]);
      end
      noise_q <= noise_d;
    end
  end

  // A stalled pipe keeps every evaluate and load valid bit
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ev_q) && $stable(ld_q))
    else $error("pipeline valid bits moved during a stall");

  // A result appears only from an evaluation in the last stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ev_q[7]))
    else $error("result without an evaluation beat");

  // A beat in the table stages is never both a load and an evaluation
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ev_q[1] && ld_q[1]) && !(ev_q[2] && ld_q[2]) && !(ev_q[3] && ld_q[3]))
    else $error("stage holds a load and an evaluation");

endmodule
